/* src/mvm_pkg.sv */
// shared constants for the matrix-vector multiply core
package mvm_pkg;

  localparam int unsigned MaxDimDefault = 4096;
  localparam int unsigned LenW          = 13;
  localparam int unsigned LenReset      = 4096;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned AccW          = 64;
  localparam int unsigned RowIndexW     = 12;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

endpackage

/* src/matrix_vector_multiply_core.sv */
// Streaming y = A*x in signed fixed point: Q16.16 elements, saturating Q32.32
// row sums. One transaction is taken per clock unless the input is stalled,
// vector loads and matrix elements alike, with no gaps between rows. A row
// result reaches the output register after the edge that accepts the row's last
// element: the x store is read at that edge, the 32x32 multiply is registered,
// and the 64-bit saturating accumulate is written into the output register. The
// x store is a single memory with one write port (vector loads) and one
// registered read port (matrix elements), so the rate is set by that one read
// per cycle. The input stalls only when a row sum is ready to leave while the
// previous one is still waiting at the output.
module matrix_vector_multiply_core #(
  parameter int unsigned MAX_DIM = mvm_pkg::MaxDimDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mvm_pkg::LenW-1:0]               cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   operation_i,
  input  logic signed [mvm_pkg::ValueW-1:0]      value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [mvm_pkg::AccW-1:0]        row_value_o,
  output logic [mvm_pkg::RowIndexW-1:0]          row_index_o,
  output logic                                   last_row_o,
  output logic                                   saturated_o
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned NW = $clog2(MAX_DIM + 1);
  localparam int unsigned NReset =
    (mvm_pkg::LenReset > MAX_DIM) ? MAX_DIM : mvm_pkg::LenReset;
  localparam int unsigned VW = mvm_pkg::ValueW;
  localparam int unsigned CW = mvm_pkg::AccW;

  typedef struct packed {
    logic          clr;
    logic          row_end;
    logic          last;
    logic [AW-1:0] row;
  } tag_t;

  logic [VW-1:0] mem [MAX_DIM];

  logic [NW-1:0] n_q;
  logic [AW-1:0] load_ptr_q;
  logic [AW-1:0] col_q;
  logic [AW-1:0] row_q;

  logic                 s1_valid_q;
  tag_t                 s1_tag_q;
  logic signed [VW-1:0] s1_a_q;
  logic signed [VW-1:0] x_q;

  logic                 s2_valid_q;
  tag_t                 s2_tag_q;
  logic signed [CW-1:0] prod_q;

  logic signed [CW-1:0] acc_q;
  logic                 sat_q;

  logic                 out_valid_q;
  logic signed [CW-1:0] row_value_q;
  logic [AW-1:0]        row_out_q;
  logic                 last_row_q;
  logic                 saturated_q;

  logic                 in_fire;
  logic                 emit;
  logic                 stall;
  logic                 col_end;
  logic                 row_last;
  logic                 ptr_last;
  logic [31:0]          len_ext;
  logic [NW-1:0]        n_d;
  logic signed [CW-1:0] sum;
  logic                 ovf;
  logic signed [CW-1:0] sum_sat;
  logic                 sat_new;
  tag_t                 s1_tag_d;

  assign emit       = s2_valid_q && s2_tag_q.row_end && !s2_tag_q.clr;
  assign stall      = emit && out_valid_q && !out_ready_i;
  assign in_ready_o = !stall;
  assign in_fire    = in_valid_i && in_ready_o;

  assign col_end  = (NW'(col_q) + NW'(1)) == n_q;
  assign row_last = (NW'(row_q) + NW'(1)) == n_q;
  assign ptr_last = (NW'(load_ptr_q) + NW'(1)) == n_q;

  always_comb begin
    len_ext = 32'(cfg_wdata_i);
    if (len_ext == 32'd0) begin
      n_d = NW'(1);
    end else if (len_ext > 32'(MAX_DIM)) begin
      n_d = NW'(MAX_DIM);
    end else begin
      n_d = NW'(len_ext);
    end
  end

  always_comb begin
    s1_tag_d.clr     = (operation_i == mvm_pkg::OP_LOAD);
    s1_tag_d.row_end = col_end;
    s1_tag_d.last    = row_last;
    s1_tag_d.row     = row_q;
  end

  always_comb begin
    sum     = acc_q + prod_q;
    ovf     = (acc_q[CW-1] == prod_q[CW-1]) && (sum[CW-1] != acc_q[CW-1]);
    sum_sat = sum;
    if (ovf) begin
      sum_sat = acc_q[CW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    sat_new = sat_q || ovf;
  end

  // x store: write port for loads, registered read port for matrix elements
  always_ff @(posedge clk_i) begin
    if (in_fire && operation_i == mvm_pkg::OP_LOAD) begin
      mem[load_ptr_q] <= value_i;
    end
    if (in_fire && operation_i == mvm_pkg::OP_MATRIX) begin
      x_q <= mem[col_q];
    end
  end

  // counters at the input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= NW'(NReset);
      load_ptr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else if (cfg_we_i) begin
      n_q        <= n_d;
      load_ptr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else if (in_fire) begin
      if (operation_i == mvm_pkg::OP_LOAD) begin
        load_ptr_q <= ptr_last ? '0 : load_ptr_q + AW'(1);
        col_q      <= '0;
        row_q      <= '0;
      end else begin
        col_q <= col_end ? '0 : col_q + AW'(1);
        if (col_end) begin
          row_q <= row_last ? '0 : row_q + AW'(1);
        end
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      if (in_fire) begin
        s1_tag_q <= s1_tag_d;
        s1_a_q   <= value_i;
      end
      if (s1_valid_q) begin
        s2_tag_q <= s1_tag_q;
        prod_q   <= CW'(s1_a_q) * CW'(x_q);
      end
    end
  end

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (cfg_we_i) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (s2_valid_q && !stall) begin
      if (s2_tag_q.clr || s2_tag_q.row_end) begin
        acc_q <= '0;
        sat_q <= 1'b0;
      end else begin
        acc_q <= sum_sat;
        sat_q <= sat_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && !stall) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && !stall) begin
      row_value_q <= sum_sat;
      row_out_q   <= s2_tag_q.row;
      last_row_q  <= s2_tag_q.last;
      saturated_q <= sat_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_value_o = row_value_q;
  assign row_index_o = mvm_pkg::RowIndexW'(row_out_q);
  assign last_row_o  = last_row_q;
  assign saturated_o = saturated_q;

  a_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q != '0 && n_q <= NW'(MAX_DIM))
    else $error("active length out of range");

  a_counters_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(col_q) < n_q && NW'(row_q) < n_q && NW'(load_ptr_q) < n_q)
    else $error("counter beyond active length");

  a_load_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && operation_i == mvm_pkg::OP_LOAD && !cfg_we_i
    |=> col_q == '0 && row_q == '0)
    else $error("vector load did not restart the product");

  a_emit_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !stall |=> out_valid_q && acc_q == '0 && !sat_q)
    else $error("row end did not reach the output or clear the accumulator");

endmodule
